// ===== hw/rtl/fpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfl_pkg
// Types and codes shared by the fixed-part free list allocator.
// ----------------------------------------------------------------------------
package fpfl_pkg;

  localparam int FPFL_INDEX_BITS = 8;

  localparam logic [7:0]  PART_COUNT_RST = 8'd255;
  localparam logic [15:0] PART_SIZE_RST  = 16'd1;

  // configuration register indexes
  localparam logic CFG_PART_COUNT = 1'b0;
  localparam logic CFG_PART_SIZE  = 1'b1;

  // request codes
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_REINIT  = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_DBL_HEAD = 2'd2;
  localparam logic [1:0] STS_BAD_REL  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] part_index;
  } fpfl_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  given_index;
    logic [23:0] given_offset;
    logic [7:0]  free_count;
  } fpfl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_SWEEP = 3'b100
  } fpfl_state_t;

endpackage

// ===== hw/rtl/fixed_part_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_part_free_list_allocator
// Pool of equal-size parts tracked by a free list held in a link memory.
//
// Requests enter on start/in_data and are taken when busy is low. Every
// request gives one result beat on out_valid/out_data, one cycle wide; the
// receiver cannot stall it. Allocate on a nonempty pool: one link memory
// read, then the result is formed in ST_READ, where busy is high. Release,
// allocate on an empty pool and unused codes: result the cycle after the
// request, busy stays low. Reinitialize: the link memory is rewritten one
// entry a cycle over all 2^INDEX_BITS entries, busy throughout, then the
// result. The registered link memory read is why an allocate passes
// through ST_READ. After reset the same rewrite pass runs (no result beat)
// while busy stays high. cfg writes are taken at any time; a reinitialize
// loads the pool size held when its rewrite pass ends.
// ----------------------------------------------------------------------------
module fixed_part_free_list_allocator
  import fpfl_pkg::*;
#(
  parameter int INDEX_BITS = FPFL_INDEX_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  fpfl_req_t   in_data,
  output logic        out_valid,
  output fpfl_rsp_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LINK_DEPTH = 1 << INDEX_BITS;

  logic [INDEX_BITS-1:0] link_mem [LINK_DEPTH];
  logic [INDEX_BITS-1:0] rd_data_r;

  fpfl_state_t           state_r, state_nxt;
  logic [INDEX_BITS-1:0] head_r, head_nxt;
  logic [7:0]            avail_r, avail_nxt;
  logic [INDEX_BITS-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic                  sweep_emit_r, sweep_emit_nxt;
  logic [7:0]            part_count_r;
  logic [15:0]           part_size_r;

  logic                  out_valid_r, out_valid_nxt;
  fpfl_rsp_t             out_data_r, out_data_nxt;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [INDEX_BITS-1:0] mem_wdata;
  logic                  mem_re;

  logic                  accept;
  logic [INDEX_BITS-1:0] rel_idx;
  logic                  rel_bad;
  logic [7:0]            head_idx8;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rel_idx   = INDEX_BITS'(in_data.part_index);
  assign head_idx8 = 8'(head_r);
  assign rel_bad   = (in_data.part_index >= part_count_r) ||
                     (32'(in_data.part_index) >= LINK_DEPTH) ||
                     (avail_r >= part_count_r);

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[head_r];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    avail_nxt      = avail_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    sweep_emit_nxt = sweep_emit_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = rel_idx;
    mem_wdata      = head_r;
    mem_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.status       = STS_OK;
          out_data_nxt.given_index  = '0;
          out_data_nxt.given_offset = '0;
          out_data_nxt.free_count   = avail_r;
          unique case (in_data.func)
            FN_ALLOC: begin
              if (avail_r == '0) begin
                out_data_nxt.status = STS_FULL;
                out_valid_nxt       = 1'b1;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_READ;
              end
            end
            FN_RELEASE: begin
              out_valid_nxt = 1'b1;
              if (rel_bad) begin
                out_data_nxt.status = STS_BAD_REL;
              end else if (avail_r != '0 && head_r == rel_idx) begin
                out_data_nxt.status = STS_DBL_HEAD;
              end else begin
                // push: new head links to old head
                mem_we                  = 1'b1;
                head_nxt                = rel_idx;
                avail_nxt               = avail_r + 8'd1;
                out_data_nxt.free_count = avail_r + 8'd1;
              end
            end
            FN_REINIT: begin
              head_nxt       = '0;
              sweep_cnt_nxt  = '0;
              sweep_emit_nxt = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        head_nxt                  = rd_data_r;
        avail_nxt                 = avail_r - 8'd1;
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = STS_OK;
        out_data_nxt.given_index  = head_idx8;
        out_data_nxt.given_offset = head_idx8 * part_size_r;
        out_data_nxt.free_count   = avail_r - 8'd1;
        state_nxt                 = ST_IDLE;
      end
      ST_SWEEP: begin
        mem_we        = 1'b1;
        mem_waddr     = sweep_cnt_r;
        mem_wdata     = sweep_cnt_r + 1'b1;
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == '1) begin
          state_nxt = ST_IDLE;
          if (sweep_emit_r) begin
            avail_nxt                 = part_count_r;
            out_valid_nxt             = 1'b1;
            out_data_nxt.status       = STS_OK;
            out_data_nxt.given_index  = '0;
            out_data_nxt.given_offset = '0;
            out_data_nxt.free_count   = part_count_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      head_r       <= '0;
      avail_r      <= PART_COUNT_RST;
      sweep_cnt_r  <= '0;
      sweep_emit_r <= 1'b0;
      out_valid_r  <= 1'b0;
      part_count_r <= PART_COUNT_RST;
      part_size_r  <= PART_SIZE_RST;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      avail_r      <= avail_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      sweep_emit_r <= sweep_emit_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PART_COUNT: part_count_r <= cfg_data[7:0];
          CFG_PART_SIZE:  part_size_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // a link read always completes into a result beat
  a_read_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_valid)
    else $error("allocate read did not produce a result");

  // an allocate on a non-empty pool must go through the link read
  a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == FN_ALLOC && avail_r != '0) |=> (state_r == ST_READ))
    else $error("allocate skipped link read");

  // no result beat while the link memory is being rewritten
  a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !out_valid)
    else $error("result beat during link rewrite");

endmodule
